[sv/mlpbp_pkg.sv]
// Package for the MLP backpropagation trainer: sizes, codes, fixed-point helpers.
// Q8.16 rounding, saturation, the piecewise sigmoid and store address maps.
// No dependencies.
package mlpbp_pkg;

  localparam int MAX_LAYERS  = 4;
  localparam int MAX_NEURONS = 16;
  localparam int FRAC_BITS   = 16;

  localparam int COLS   = MAX_NEURONS + 1;
  localparam int WDEPTH = (MAX_LAYERS - 1) * MAX_NEURONS * COLS;
  localparam int ADEPTH = MAX_LAYERS * COLS;
  localparam int GDEPTH = (MAX_LAYERS - 1) * MAX_NEURONS;
  localparam int EDEPTH = MAX_NEURONS;

  localparam int WAW = $clog2(WDEPTH);
  localparam int AAW = $clog2(ADEPTH);
  localparam int GAW = $clog2(GDEPTH);
  localparam int EAW = $clog2(EDEPTH);
  localparam int LW  = $clog2(MAX_LAYERS);
  localparam int RW  = $clog2(MAX_NEURONS);
  localparam int NW  = $clog2(MAX_NEURONS + 1);

  localparam int VW   = 24;   // Q8.16 value
  localparam int PW   = 2 * (VW + 1);
  localparam int ACCW = PW + 6;
  localparam int TW   = 68;   // wide intermediate
  localparam int RATEW = 16;

  localparam int ONE_FX = 1 << FRAC_BITS;
  localparam int VMAX_I = (1 << (VW - 1)) - 1;
  localparam int VMIN_I = -(1 << (VW - 1));

  // sigmoid segments on |x|, tested in order; thresholds are on 8*|x|
  localparam int SIG_LIM   [4] = '{40 * ONE_FX, 19 * ONE_FX, 8 * ONE_FX, 0};
  localparam int SIG_SHIFT [4] = '{31, 5, 3, 2};
  localparam int SIG_OFF   [4] = '{32 * ONE_FX / 32, 27 * ONE_FX / 32,
                                   20 * ONE_FX / 32, 16 * ONE_FX / 32};

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_INPUT  = 2'd2,
    REQ_TARGET = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    KIND_ACT   = 2'd0,
    KIND_WREAD = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CFG_LRATE  = 3'd0,
    CFG_MOM    = 3'd1,
    CFG_BIAS   = 3'd2,
    CFG_LAYERS = 3'd3,
    CFG_SIZE0  = 3'd4,
    CFG_SIZE1  = 3'd5,
    CFG_SIZE2  = 3'd6,
    CFG_SIZE3  = 3'd7
  } cfg_index_t;

  function automatic logic signed [VW-1:0] sat24(input logic signed [TW-1:0] v);
    if (v > TW'(VMAX_I)) return VW'(VMAX_I);
    if (v < TW'(VMIN_I)) return VW'(VMIN_I);
    return v[VW-1:0];
  endfunction

  // round half away from zero, then shift right
  function automatic logic signed [TW-1:0] rnd_shift(input logic signed [TW-1:0] v,
                                                     input int sh);
    logic signed [TW-1:0] h;
    logic signed [TW-1:0] n;
    logic signed [TW-1:0] t;
    h = TW'(1) <<< (sh - 1);
    n = $signed({{(TW-1){1'b0}}, v[TW-1]});
    t = v + h - n;
    return t >>> sh;
  endfunction

  function automatic logic signed [VW-1:0] sigmoid(input logic signed [VW-1:0] s);
    logic signed [VW:0]   sx;
    logic [VW:0]          x;
    logic [VW+3:0]        x8;
    logic signed [VW+1:0] y;
    logic                 hit;
    sx  = {s[VW-1], s};
    x   = s[VW-1] ? unsigned'(-sx) : unsigned'(sx);
    x8  = {x, 3'b000};
    y   = (VW+2)'(ONE_FX);
    hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (!hit && (x8 >= (VW+4)'(SIG_LIM[k]))) begin
        y   = $signed((VW+2)'(x >> SIG_SHIFT[k])) + (VW+2)'(SIG_OFF[k]);
        hit = 1'b1;
      end
    end
    if (s[VW-1]) y = (VW+2)'(ONE_FX) - y;
    return sat24(TW'(y));
  endfunction

  function automatic logic [WAW-1:0] wix(input logic [LW-1:0] lay, input logic [RW-1:0] row,
                                         input logic [NW-1:0] col);
    return WAW'((int'(lay) * MAX_NEURONS + int'(row)) * COLS + int'(col));
  endfunction

  function automatic logic [AAW-1:0] aix(input logic [LW-1:0] lay, input logic [NW-1:0] col);
    return AAW'(int'(lay) * COLS + int'(col));
  endfunction

  function automatic logic [GAW-1:0] gix(input logic [LW-1:0] lay, input logic [RW-1:0] row);
    return GAW'(int'(lay) * MAX_NEURONS + int'(row));
  endfunction

endpackage

[sv/mlpbp_if.sv]
// Valid/ready channel interfaces for the MLP trainer: requests, results, config writes.
// Depends on mlpbp_pkg for field widths.
interface mlpbp_req_if import mlpbp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [1:0]           layer;
  logic [RW-1:0]        row;
  logic [NW-1:0]        col;
  logic signed [VW-1:0] value;
  logic                 last;

  modport source (output valid, req_type, layer, row, col, value, last, input ready);
  modport sink   (input valid, req_type, layer, row, col, value, last, output ready);
endinterface

interface mlpbp_rsp_if import mlpbp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [NW-1:0]        index;
  logic signed [VW-1:0] result_value;
  logic                 end_of_run;

  modport source (output valid, kind, index, result_value, end_of_run, input ready);
  modport sink   (input valid, kind, index, result_value, end_of_run, output ready);
endinterface

interface mlpbp_cfg_if import mlpbp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       index;
  logic [RATEW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/mlp_backprop_momentum_trainer_core.sv]
// Top level of the MLP trainer: sequencer, one shared 25x25 multiplier, all stores.
// Depends on mlpbp_pkg and the channel interfaces in mlpbp_if.sv.
//
// Usage: after reset the block clears every word of the momentum store and takes
// no request meanwhile (config writes are always taken). A weight write or an
// input element is taken in the idle state; a weight read or a target element
// passes through a state of its own first. All multiplies go through one registered
// 25x25 multiplier: the forward pass does a multiply-accumulate per weight and
// rounds and applies the sigmoid per neuron; training forms the output gradients,
// the backpropagated terms of each hidden neuron and then updates each weight in use
// with momentum. Activations leave one at a time, each once the result side is free.
module mlp_backprop_momentum_trainer_core import mlpbp_pkg::*; (
  input  logic clk,
  input  logic rst,
  mlpbp_req_if.sink   req,
  mlpbp_rsp_if.source rsp,
  mlpbp_cfg_if.sink   cfg
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_RD    = 10'b0000000100,
    S_TGT   = 10'b0000001000,
    S_FWD   = 10'b0000010000,
    S_OUT   = 10'b0000100000,
    S_GOUT  = 10'b0001000000,
    S_GHID  = 10'b0010000000,
    S_UPD   = 10'b0100000000,
    S_ACK   = 10'b1000000000
  } state_t;

  state_t state;
  logic [2:0]     ph;
  logic [LW-1:0]  m;
  logic [NW-1:0]  r, c, pos;
  logic [WAW-1:0] clr;

  logic [RATEW-1:0] learning_rate, momentum;
  logic             bias_enable;
  logic [2:0]       layer_count;
  logic [NW-1:0]    size_layer [4];

  logic signed [ACCW-1:0] acc;
  logic signed [VW-1:0]   sreg, phi, rq_val;
  logic signed [VW:0]     dreg, t2;
  logic signed [PW-1:0]   prod, tlo;
  logic signed [TW-1:0]   treg;
  logic signed [32:0]     t1;
  logic [WAW-1:0]         rq_addr;
  logic                   rq_ok, rq_last;

  logic                 out_valid, out_end;
  kind_t                out_kind;
  logic [NW-1:0]        out_index;
  logic signed [VW-1:0] out_value;

  // stores
  logic signed [VW-1:0] wmem [WDEPTH];
  logic signed [VW-1:0] mmem [WDEPTH];
  logic signed [VW-1:0] amem [ADEPTH];
  logic signed [VW-1:0] gmem [GDEPTH];
  logic signed [VW-1:0] emem [EDEPTH];
  logic signed [VW-1:0] w_q, m_q, a_q, g_q, e_q;

  logic [WAW-1:0] w_ra, w_wa, m_ra, m_wa;
  logic [AAW-1:0] a_ra, a_wa;
  logic [GAW-1:0] g_ra, g_wa;
  logic [EAW-1:0] e_ra, e_wa;
  logic w_we, m_we, a_we, g_we, e_we;
  logic signed [VW-1:0] w_wd, m_wd, a_wd, g_wd, e_wd;

  // geometry and helpers
  logic [2:0]     nl;
  logic [LW-1:0]  lt, top;
  logic [NW-1:0]  lsz [4];
  logic [NW-1:0]  c_inc, c_next, r_inc, pos_inc;
  logic           col_more;
  logic           req_fire, out_free, addr_ok;
  logic signed [VW:0]   mul_a, mul_b;
  logic signed [VW-1:0] nv, wnew, grad_new;

  assign req_fire = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign out_free = !out_valid || rsp.ready;

  assign rsp.valid        = out_valid;
  assign rsp.kind         = out_kind;
  assign rsp.index        = out_index;
  assign rsp.result_value = out_value;
  assign rsp.end_of_run   = out_end;

  assign addr_ok = (int'(req.layer) < MAX_LAYERS - 1) && (int'(req.col) <= MAX_NEURONS);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (size_layer[i] == '0) lsz[i] = NW'(1);
      else if (int'(size_layer[i]) > MAX_NEURONS) lsz[i] = NW'(MAX_NEURONS);
      else lsz[i] = size_layer[i];
    end
    if (layer_count < 3'd2) nl = 3'd2;
    else if (int'(layer_count) > MAX_LAYERS) nl = 3'(MAX_LAYERS);
    else nl = layer_count;
    lt      = LW'(nl - 3'd1);
    top     = LW'(nl - 3'd2);
    r_inc   = r + NW'(1);
    c_inc   = c + NW'(1);
    pos_inc = (pos == '1) ? pos : pos + NW'(1);
    // next source column: real inputs, then the bias column
    if (c_inc < lsz[m]) begin
      c_next = c_inc;  col_more = 1'b1;
    end else if (bias_enable && int'(c) != MAX_NEURONS) begin
      c_next = NW'(MAX_NEURONS);  col_more = 1'b1;
    end else begin
      c_next = c_inc;  col_more = 1'b0;
    end
  end

  assign nv       = sat24(TW'(t1) + TW'(t2));
  assign wnew     = sat24(TW'(w_q) + TW'(nv));
  assign grad_new = sat24(rnd_shift(TW'(prod), FRAC_BITS));

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_FWD: begin
        mul_a = VW'(w_q);  mul_b = VW'(a_q);
      end
      S_GOUT: begin
        if (ph == 3'd3) begin
          mul_a = e_q;  mul_b = dreg;
        end else begin
          mul_a = a_q;  mul_b = (VW+1)'(ONE_FX) - (VW+1)'(a_q);
        end
      end
      S_GHID: begin
        if (ph == 3'd1) begin
          mul_a = w_q;  mul_b = g_q;
        end else if (ph == 3'd6) begin
          mul_a = sreg;  mul_b = dreg;
        end else begin
          mul_a = a_q;  mul_b = (VW+1)'(ONE_FX) - (VW+1)'(a_q);
        end
      end
      S_UPD: begin
        case (ph)
          3'd1: begin mul_a = g_q;  mul_b = a_q; end
          3'd2: begin
            mul_a = $signed({1'b0, prod[VW-1:0]});
            mul_b = $signed((VW+1)'(learning_rate));
          end
          3'd3: begin mul_a = phi;  mul_b = $signed((VW+1)'(learning_rate)); end
          3'd4: begin mul_a = m_q;  mul_b = $signed((VW+1)'(momentum)); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // memory port control
  always_comb begin
    w_ra = rq_addr;
    w_we = 1'b0;  w_wa = wix(m, r[RW-1:0], c);  w_wd = wnew;
    m_ra = wix(m, r[RW-1:0], c);
    m_we = 1'b0;  m_wa = wix(m, r[RW-1:0], c);  m_wd = nv;
    a_ra = aix(m, c);
    a_we = 1'b0;  a_wa = aix(LW'(m + 1'b1), r);  a_wd = sigmoid(sreg);
    g_ra = gix(m, r[RW-1:0]);
    g_we = 1'b0;  g_wa = gix(m, r[RW-1:0]);  g_wd = grad_new;
    e_ra = r[EAW-1:0];
    e_we = 1'b0;  e_wa = pos[EAW-1:0];
    e_wd = sat24(TW'(rq_val) - TW'(a_q));
    unique case (state)
      S_CLEAR: begin
        m_we = 1'b1;  m_wa = clr;  m_wd = '0;
      end
      S_IDLE: begin
        w_wa = wix(req.layer, req.row, req.col);
        w_wd = req.value;
        w_we = req_fire && (req.req_type == REQ_WRITE) && addr_ok;
        a_wa = aix('0, pos);
        a_wd = req.value;
        a_we = req_fire && (req.req_type == REQ_INPUT) && (pos < lsz[0]);
      end
      S_RD: ;
      S_TGT: begin
        a_ra = aix(lt, pos);
        e_we = (ph == 3'd1) && (pos < lsz[lt]);
      end
      S_FWD: begin
        w_ra = wix(m, r[RW-1:0], c);
        if (ph == 3'd0) begin
          a_wa = aix(m, NW'(MAX_NEURONS));
          a_wd = VW'(ONE_FX);
          a_we = bias_enable;
        end else begin
          a_we = (ph == 3'd4);
        end
      end
      S_OUT:  a_ra = aix(lt, r);
      S_GOUT: begin
        a_ra = aix(lt, r);
        g_wa = gix(top, r[RW-1:0]);
        g_we = (ph == 3'd4);
      end
      S_GHID: begin
        w_ra = wix(LW'(m + 1'b1), c[RW-1:0], r);
        a_ra = aix(LW'(m + 1'b1), r);
        g_ra = gix(LW'(m + 1'b1), c[RW-1:0]);
        g_we = (ph == 3'd7);
      end
      S_UPD: begin
        w_ra = wix(m, r[RW-1:0], c);
        w_we = (ph == 3'd6);
        m_we = (ph == 3'd6);
      end
      S_ACK: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_wa] <= w_wd;
    w_q <= wmem[w_ra];
  end

  always_ff @(posedge clk) begin
    if (m_we) mmem[m_wa] <= m_wd;
    m_q <= mmem[m_ra];
  end

  always_ff @(posedge clk) begin
    if (a_we) amem[a_wa] <= a_wd;
    a_q <= amem[a_ra];
  end

  always_ff @(posedge clk) begin
    if (g_we) gmem[g_wa] <= g_wd;
    g_q <= gmem[g_ra];
  end

  always_ff @(posedge clk) begin
    if (e_we) emem[e_wa] <= e_wd;
    e_q <= emem[e_ra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      ph            <= '0;
      clr           <= '0;
      pos           <= '0;
      out_valid     <= 1'b0;
      learning_rate <= RATEW'(6554);
      momentum      <= '0;
      bias_enable   <= 1'b1;
      layer_count   <= 3'd3;
      for (int i = 0; i < 4; i++) size_layer[i] <= NW'(MAX_NEURONS);
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          CFG_LRATE:  learning_rate <= cfg.data;
          CFG_MOM:    momentum      <= cfg.data;
          CFG_BIAS:   bias_enable   <= cfg.data[0];
          CFG_LAYERS: layer_count   <= cfg.data[2:0];
          CFG_SIZE0, CFG_SIZE1, CFG_SIZE2, CFG_SIZE3:
            size_layer[cfg.index[1:0]] <= cfg.data[NW-1:0];
          default: ;
        endcase
      end
      if (rsp.ready) out_valid <= 1'b0;

      unique case (state)
        S_CLEAR: begin
          clr <= clr + WAW'(1);
          if (int'(clr) == WDEPTH - 1) state <= S_IDLE;
        end

        S_IDLE: begin
          if (req_fire) begin
            case (req.req_type)
              REQ_READ: begin
                rq_addr <= wix(req.layer, req.row, req.col);
                rq_ok   <= addr_ok;
                ph      <= '0;
                state   <= S_RD;
              end
              REQ_INPUT: begin
                pos <= pos_inc;
                if (req.last) begin
                  pos   <= '0;
                  m     <= '0;
                  r     <= '0;
                  c     <= '0;
                  acc   <= '0;
                  ph    <= '0;
                  state <= S_FWD;
                end
              end
              REQ_TARGET: begin
                rq_val  <= req.value;
                rq_last <= req.last;
                ph      <= '0;
                state   <= S_TGT;
              end
              default: ;
            endcase
          end
        end

        S_RD: begin
          if (ph == 3'd0) ph <= 3'd1;
          else if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_WREAD;
            out_index <= '0;
            out_value <= rq_ok ? w_q : '0;
            out_end   <= 1'b1;
            state     <= S_IDLE;
          end
        end

        S_TGT: begin
          if (ph == 3'd0) ph <= 3'd1;
          else begin
            pos   <= pos_inc;
            state <= S_IDLE;
            if (rq_last) begin
              pos   <= '0;
              r     <= '0;
              ph    <= '0;
              state <= S_GOUT;
            end
          end
        end

        S_FWD: begin
          case (ph)
            3'd0: ph <= 3'd1;
            3'd1: ph <= 3'd2;
            3'd2: begin
              acc <= acc + ACCW'(prod);
              if (col_more) begin
                c  <= c_next;
                ph <= 3'd0;
              end else begin
                ph <= 3'd3;
              end
            end
            3'd3: begin
              sreg <= sat24(rnd_shift(TW'(acc), FRAC_BITS));
              ph   <= 3'd4;
            end
            default: begin
              // neuron written; move to next neuron, next layer or emit
              acc <= '0;
              c   <= '0;
              ph  <= '0;
              if (r_inc < lsz[LW'(m + 1'b1)]) begin
                r <= r_inc;
              end else if (({1'b0, m} + 3'd2) < nl) begin
                m <= LW'(m + 1'b1);
                r <= '0;
              end else begin
                r     <= '0;
                state <= S_OUT;
              end
            end
          endcase
        end

        S_OUT: begin
          if (ph == 3'd0) ph <= 3'd1;
          else if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_ACT;
            out_index <= r;
            out_value <= a_q;
            out_end   <= (r_inc == lsz[lt]);
            ph        <= '0;
            r         <= r_inc;
            if (r_inc == lsz[lt]) state <= S_IDLE;
          end
        end

        S_GOUT: begin
          case (ph)
            3'd0: ph <= 3'd1;
            3'd1: ph <= 3'd2;
            3'd2: begin
              dreg <= rnd_shift(TW'(prod), FRAC_BITS)[VW:0];
              ph   <= 3'd3;
            end
            3'd3: ph <= 3'd4;
            default: begin
              ph <= '0;
              if (r_inc < lsz[lt]) begin
                r <= r_inc;
              end else begin
                r   <= '0;
                c   <= '0;
                acc <= '0;
                if (top != '0) begin
                  m     <= LW'(top - 1'b1);
                  state <= S_GHID;
                end else begin
                  m     <= '0;
                  state <= S_UPD;
                end
              end
            end
          endcase
        end

        S_GHID: begin
          case (ph)
            3'd0: ph <= 3'd1;
            3'd1: ph <= 3'd2;
            3'd2: begin
              acc <= acc + ACCW'(prod);
              if (c_inc < lsz[LW'(m + 2'd2)]) begin
                c  <= c_inc;
                ph <= 3'd0;
              end else begin
                ph <= 3'd3;
              end
            end
            3'd3: begin
              sreg <= sat24(rnd_shift(TW'(acc), FRAC_BITS));
              ph   <= 3'd4;
            end
            3'd4: ph <= 3'd5;
            3'd5: begin
              dreg <= rnd_shift(TW'(prod), FRAC_BITS)[VW:0];
              ph   <= 3'd6;
            end
            3'd6: ph <= 3'd7;
            default: begin
              acc <= '0;
              c   <= '0;
              ph  <= '0;
              if (r_inc < lsz[LW'(m + 1'b1)]) begin
                r <= r_inc;
              end else if (m != '0) begin
                m <= LW'(m - 1'b1);
                r <= '0;
              end else begin
                r     <= '0;
                state <= S_UPD;
              end
            end
          endcase
        end

        S_UPD: begin
          case (ph)
            3'd0: ph <= 3'd1;
            3'd1: ph <= 3'd2;
            3'd2: begin
              phi <= prod[2*VW-1:VW];
              ph  <= 3'd3;
            end
            3'd3: begin
              tlo <= prod;
              ph  <= 3'd4;
            end
            3'd4: begin
              treg <= (TW'(prod) <<< VW) + TW'(tlo);
              ph   <= 3'd5;
            end
            3'd5: begin
              t1 <= rnd_shift(treg, FRAC_BITS + RATEW)[32:0];
              t2 <= rnd_shift(TW'(prod), RATEW)[VW:0];
              ph <= 3'd6;
            end
            default: begin
              // weight and momentum written this cycle; advance
              ph <= '0;
              if (col_more) begin
                c <= c_next;
              end else begin
                c <= '0;
                if (r_inc < lsz[LW'(m + 1'b1)]) begin
                  r <= r_inc;
                end else if (({1'b0, m} + 3'd2) < nl) begin
                  m <= LW'(m + 1'b1);
                  r <= '0;
                end else begin
                  state <= S_ACK;
                end
              end
            end
          endcase
        end

        S_ACK: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_DONE;
            out_index <= '0;
            out_value <= '0;
            out_end   <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_wwrite_place: assert property (@(posedge clk) disable iff (rst)
    w_we |-> (state == S_IDLE || state == S_UPD))
    else $error("weight store written outside request or update");

  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_FWD && ph == 3'd0 && c == '0) |-> (acc == '0))
    else $error("accumulator not clear at start of neuron");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> ($stable(out_value) && $stable(out_kind)))
    else $error("pending result overwritten");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (m_we && !req.ready))
    else $error("clearing pass not in control of momentum store");
`endif

endmodule
